### sv/smc_pkg.sv
// Shared constants, word types and status struct for the spectral magnitude/centroid unit.
package smc_pkg;

    localparam int NUM_BINS           = 64;
    localparam int CENTROID_FRAC_BITS = 8;

    localparam int COMP_W     = 32;
    localparam int MAG_W      = 32;
    localparam int BIN_NUM_W  = 6;
    localparam int MEAN_W     = 32;
    localparam int CENT_W     = 14;
    localparam int CNT_W      = $clog2(NUM_BINS);
    localparam int MSUM_W     = MAG_W + CNT_W;
    localparam int WSUM_W     = MAG_W + 2 * CNT_W;
    localparam int RAD_W      = 2 * MAG_W;
    localparam int SQ_STEPS   = MAG_W;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
    localparam int DVD_W      = WSUM_W + CENTROID_FRAC_BITS;
    localparam int DVS_W      = MSUM_W;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    typedef struct packed {
        logic signed [COMP_W-1:0] bin_real;
        logic signed [COMP_W-1:0] bin_imag;
    } bin_word_t;

    typedef struct packed {
        logic [MAG_W-1:0]     bin_magnitude;
        logic [BIN_NUM_W-1:0] bin_number;
        logic                 block_done;
        logic [MEAN_W-1:0]    mean_magnitude;
        logic [CENT_W-1:0]    centroid;
        logic                 centroid_valid;
    } result_word_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

### sv/smc_isqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
module smc_isqrt
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [smc_pkg::RAD_W-1:0]  radicand,
    output smc_pkg::unit_sts_t         sts,
    output logic [smc_pkg::MAG_W-1:0]  root
);
    import smc_pkg::*;

    localparam int REM_W = MAG_W + 3;

    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [MAG_W-1:0]    root_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic                run_reg;
    logic                done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= SQ_CNT_W'(SQ_STEPS - 1);
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (fits)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[MAG_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign root     = root_reg;

endmodule

### sv/smc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle; shared by mean and centroid.
module smc_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [smc_pkg::DVD_W-1:0]  dividend,
    input  logic [smc_pkg::DVS_W-1:0]  divisor,
    output smc_pkg::unit_sts_t         sts,
    output logic [smc_pkg::DVD_W-1:0]  quotient
);
    import smc_pkg::*;

    // dvd_reg shifts the dividend out at the top and the quotient in at the bottom
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [DVS_W:0] rem_shift;
    logic [DVS_W:0] rem_diff;
    logic           fits;

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg <= dividend;
                dvs_reg <= divisor;
                rem_reg <= '0;
                cnt_reg <= DIV_CNT_W'(DVD_W - 1);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
                rem_reg <= fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign quotient = dvd_reg;

endmodule

### sv/spectral_magnitude_centroid_unit.sv
// Spectral magnitude and centroid unit: top level with bin sequencer and accumulators.
// Per bin: two squares, the 32-step square root and the accumulate, then the result strobe.
// Last bin of a block: the serial divider then runs once for the mean and once for
// the centroid before the result strobe.
// A new bin is accepted only while idle; busy falls in the strobe cycle, results cannot stall.
// Reset: asynchronous, clears bin counter, both sums and the sequencer; no clearing pass.
module spectral_magnitude_centroid_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  smc_pkg::bin_word_t    sample,
    output logic                  strobe,
    output smc_pkg::result_word_t result
);
    import smc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_ROOT_GO,
        S_ROOT,
        S_ACC,
        S_MEAN_GO,
        S_MEAN,
        S_CENT_GO,
        S_CENT
    } state_t;

    state_t          state_reg;
    logic [MAG_W-1:0]  re_abs_reg;
    logic [MAG_W-1:0]  im_abs_reg;
    logic [RAD_W-1:0]  sq_re_reg;
    logic [RAD_W-1:0]  sq_im_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  bin_cnt_reg;
    logic [MSUM_W-1:0] msum_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic              strobe_reg;
    result_word_t      result_reg;

    logic [MSUM_W-1:0] msum_next;
    logic [WSUM_W-1:0] wsum_next;
    logic [MAG_W-1:0]  re_abs;
    logic [MAG_W-1:0]  im_abs;
    logic [MAG_W-1:0]  mul_a;
    logic [MAG_W-1:0]  mul_b;
    logic [RAD_W-1:0]  prod;
    logic              accept;
    logic              last_bin;

    logic              root_start;
    unit_sts_t         root_sts;
    logic [MAG_W-1:0]  root;
    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    unit_sts_t         div_sts;
    logic [DVD_W-1:0]  quotient;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign last_bin = (bin_cnt_reg == CNT_W'(NUM_BINS - 1));

    // most negative input wraps to 2^31, which is right as unsigned
    assign re_abs = sample.bin_real[COMP_W-1] ? (~sample.bin_real + 1'b1) : sample.bin_real;
    assign im_abs = sample.bin_imag[COMP_W-1] ? (~sample.bin_imag + 1'b1) : sample.bin_imag;

    // one shared multiplier: two squares, then magnitude times bin index
    always_comb
    begin
        case (state_reg)
            S_SQ_RE:
            begin
                mul_a = re_abs_reg;
                mul_b = re_abs_reg;
            end
            S_SQ_IM:
            begin
                mul_a = im_abs_reg;
                mul_b = im_abs_reg;
            end
            default:
            begin
                mul_a = mag_reg;
                mul_b = MAG_W'(bin_cnt_reg);
            end
        endcase
    end

    assign prod      = mul_a * mul_b;
    assign msum_next = msum_reg + MSUM_W'(mag_reg);
    assign wsum_next = wsum_reg + WSUM_W'(prod);

    assign root_start   = (state_reg == S_ROOT_GO);
    assign div_start    = (state_reg == S_MEAN_GO) || (state_reg == S_CENT_GO);
    assign div_dividend = (state_reg == S_CENT_GO)
                          ? (DVD_W'(wsum_reg) << CENTROID_FRAC_BITS)
                          : DVD_W'(msum_reg);
    assign div_divisor  = (state_reg == S_CENT_GO) ? msum_reg : DVS_W'(NUM_BINS);

    smc_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sq_re_reg + sq_im_reg),
        .sts      (root_sts),
        .root     (root)
    );

    smc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bin_cnt_reg <= '0;
            msum_reg    <= '0;
            wsum_reg    <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        re_abs_reg <= re_abs;
                        im_abs_reg <= im_abs;
                        state_reg  <= S_SQ_RE;
                    end
                end
                S_SQ_RE:
                begin
                    sq_re_reg <= prod;
                    state_reg <= S_SQ_IM;
                end
                S_SQ_IM:
                begin
                    sq_im_reg <= prod;
                    state_reg <= S_ROOT_GO;
                end
                S_ROOT_GO:
                begin
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (root_sts.done)
                    begin
                        mag_reg   <= root;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    result_reg.bin_magnitude  <= mag_reg;
                    result_reg.bin_number     <= BIN_NUM_W'(bin_cnt_reg);
                    result_reg.block_done     <= last_bin;
                    result_reg.mean_magnitude <= '0;
                    result_reg.centroid       <= '0;
                    result_reg.centroid_valid <= 1'b0;
                    msum_reg <= msum_next;
                    wsum_reg <= wsum_next;
                    if (last_bin)
                    begin
                        state_reg <= S_MEAN_GO;
                    end
                    else
                    begin
                        bin_cnt_reg <= bin_cnt_reg + 1'b1;
                        strobe_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_MEAN_GO:
                begin
                    state_reg <= S_MEAN;
                end
                S_MEAN:
                begin
                    if (div_sts.done)
                    begin
                        result_reg.mean_magnitude <= quotient[MEAN_W-1:0];
                        state_reg <= S_CENT_GO;
                    end
                end
                S_CENT_GO:
                begin
                    state_reg <= S_CENT;
                end
                S_CENT:
                begin
                    if (div_sts.done)
                    begin
                        // zero sum: divider output is junk, force centroid to 0
                        if (msum_reg != '0)
                        begin
                            result_reg.centroid       <= quotient[CENT_W-1:0];
                            result_reg.centroid_valid <= 1'b1;
                        end
                        bin_cnt_reg <= '0;
                        msum_reg    <= '0;
                        wsum_reg    <= '0;
                        strobe_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobe without a bin in progress");

    a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        root_sts.done |-> (state_reg == S_ROOT))
        else $error("square root finished outside its wait state");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_MEAN) || (state_reg == S_CENT))
        else $error("divider finished outside a wait state");

    a_last_bin_number: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.block_done) |-> (result.bin_number == BIN_NUM_W'(NUM_BINS - 1)))
        else $error("block end flagged on a bin other than the last");

    a_mid_block_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.block_done) |->
            (!result.centroid_valid && result.centroid == '0 && result.mean_magnitude == '0))
        else $error("block statistics on a bin that does not end a block");

endmodule
